@@ design/mbc_pkg.sv @@
// Shared types and constants for the message batch coalescer.
package mbc_pkg;

    localparam int MAX_MESSAGES = 8;
    localparam int NUM_SLOTS    = 8;
    localparam int SLOT_IDX_W   = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = 2;
    localparam int QUEUE_CNT_W  = 3;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT    = 1'b1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [16:0] LIMIT_RESET   = 17'd4096;
    localparam logic [31:0] ROUND_ADD     = 32'd63;
    localparam logic [31:0] HEADER_BYTES  = 32'd64;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 328;

    typedef logic [NUM_SLOTS-1:0][31:0] t_slots;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] send_len;
        logic [3:0]  count;
        t_slots      slots;
        logic        run_end;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    item0;
        t_result    item1;
    } t_push;

endpackage

@@ design/mbc_core.sv @@
// Batch state, configuration registers and flush decisions for one transfer per cycle while i_accept is high.
module mbc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_command,
    input  logic [31:0]                    i_dest,
    input  logic [31:0]                    i_msg_length,
    output mbc_pkg::t_push                 o_push
);
    import mbc_pkg::*;

    logic [31:0] r_timeout;
    logic [16:0] r_limit;
    logic        r_open;
    logic [31:0] r_wait;
    logic [34:0] r_total;
    logic [3:0]  r_count;
    t_slots      r_slots;
    logic [31:0] r_last_dest;

    logic        n_open;
    logic [31:0] n_wait;
    logic [34:0] n_total;
    logic [3:0]  n_count;
    t_slots      n_slots;
    logic [31:0] n_last_dest;

    logic [31:0] w_ticks;
    logic        w_flush_a;
    logic        w_flush_b;
    logic [34:0] w_base_total;
    logic [3:0]  w_base_count;
    t_slots      w_base_slots;
    logic [31:0] w_rounded;
    logic [34:0] w_msg_total;
    logic [3:0]  w_msg_count;
    t_slots      w_msg_slots;
    t_result     w_res_a;
    t_result     w_res_b;

    always_comb begin
        w_ticks   = r_wait + 32'd1;
        w_flush_a = r_open && (w_ticks >= r_timeout);

        w_base_total = w_flush_a ? '0 : r_total;
        w_base_count = w_flush_a ? '0 : r_count;
        w_base_slots = w_flush_a ? '0 : r_slots;

        w_rounded   = (i_msg_length + ROUND_ADD) & ~ROUND_ADD;
        w_msg_total = w_base_total + {3'b000, w_rounded};
        w_msg_count = w_base_count + 4'd1;
        w_msg_slots = w_base_slots;
        w_msg_slots[w_base_count[SLOT_IDX_W-1:0]] = w_rounded;
        w_flush_b = i_command &&
                    ((w_msg_total >= {18'd0, r_limit}) || (w_msg_count == 4'(MAX_MESSAGES)));

        w_res_a.dest     = r_last_dest;
        w_res_a.send_len = r_total[31:0] + HEADER_BYTES;
        w_res_a.count    = r_count;
        w_res_a.slots    = r_slots;
        w_res_a.run_end  = !w_flush_b;

        w_res_b.dest     = i_dest;
        w_res_b.send_len = w_msg_total[31:0] + HEADER_BYTES;
        w_res_b.count    = w_msg_count;
        w_res_b.slots    = w_msg_slots;
        w_res_b.run_end  = 1'b1;

        o_push.item0 = w_flush_a ? w_res_a : w_res_b;
        o_push.item1 = w_res_b;
        if (!i_accept) begin
            o_push.num = 2'd0;
        end else begin
            o_push.num = {1'b0, w_flush_a} + {1'b0, w_flush_b};
        end

        n_open      = r_open;
        n_wait      = r_wait;
        n_total     = r_total;
        n_count     = r_count;
        n_slots     = r_slots;
        n_last_dest = r_last_dest;
        if (i_accept) begin
            n_open  = r_open && !w_flush_a;
            n_wait  = w_flush_a ? '0 : (r_open ? w_ticks : r_wait);
            n_total = w_base_total;
            n_count = w_base_count;
            n_slots = w_base_slots;
            if (i_command) begin
                n_last_dest = i_dest;
                if (w_flush_b) begin
                    n_open  = 1'b0;
                    n_wait  = '0;
                    n_total = '0;
                    n_count = '0;
                    n_slots = '0;
                end else begin
                    n_open  = 1'b1;
                    n_total = w_msg_total;
                    n_count = w_msg_count;
                    n_slots = w_msg_slots;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_limit     <= LIMIT_RESET;
            r_open      <= 1'b0;
            r_wait      <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_slots     <= '0;
            r_last_dest <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BATCH_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_BYTE_LIMIT:    r_limit   <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            r_open      <= n_open;
            r_wait      <= n_wait;
            r_total     <= n_total;
            r_count     <= n_count;
            r_slots     <= n_slots;
            r_last_dest <= n_last_dest;
        end
    end

endmodule

@@ design/mbc_out_queue.sv @@
// Four-entry result queue taking up to two results per cycle and giving one.
module mbc_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbc_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_space,
    output logic             o_valid,
    output mbc_pkg::t_result o_head
);
    import mbc_pkg::*;

    t_result                r_entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_head;
    logic [QUEUE_PTR_W-1:0] r_tail;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] w_tail1;
    logic                   w_pop;

    assign w_tail1 = r_tail + QUEUE_PTR_W'(1);
    assign o_valid = (r_count != '0);
    assign w_pop   = i_pop && o_valid;
    assign o_space = (r_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign o_head  = r_entries[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_entries[r_tail] <= i_push.item0;
        end
        if (i_push.num == 2'd2) begin
            r_entries[w_tail1] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + QUEUE_PTR_W'(i_push.num);
            r_head  <= r_head + QUEUE_PTR_W'(w_pop);
            r_count <= r_count + QUEUE_CNT_W'(i_push.num) - QUEUE_CNT_W'(w_pop);
        end
    end

endmodule

@@ design/message_batch_coalescer.sv @@
// Top level of the message batch coalescer.
// A flushed result is written into the result queue and reaches the master port from its head.
// Throughput: one input transfer per cycle while the four-entry result queue has two free
// entries; a transfer that flushes twice pushes two results, which leave the master port
// one per handshake.
// Reset (synchronous, active low) clears the batch, restores register defaults, empties the queue.
module message_batch_coalescer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // dest [31:0], msg_length [63:32]
    input  logic [mbc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command [0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_dest [31:0], send_length [63:32], batch_count [67:64],
    // slot_len_0..slot_len_7 [323:68] (32 bits each, ascending), zero [327:324]
    output logic [mbc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // run_end
    output logic                           m_axis_tlast
);
    import mbc_pkg::*;

    t_push   w_push;
    t_result w_head;
    logic    w_space;
    logic    w_accept;

    assign s_axis_tready = w_space;
    assign w_accept      = s_axis_tvalid && w_space;

    mbc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_command    (s_axis_tuser),
        .i_dest       (s_axis_tdata[31:0]),
        .i_msg_length (s_axis_tdata[63:32]),
        .o_push       (w_push)
    );

    mbc_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (m_axis_tready),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .o_head  (w_head)
    );

    assign m_axis_tdata = {4'b0000, w_head.slots, w_head.count, w_head.send_len, w_head.dest};
    assign m_axis_tlast = w_head.run_end;

endmodule

@@ design/mbc_checker.sv @@
// Port-level checks for the message batch coalescer, bound to the top level.
module mbc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mbc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                           m_axis_tlast
);
    import mbc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[67:64] != 4'd0) &&
                          (m_axis_tdata[67:64] <= 4'(MAX_MESSAGES)))
        else $error("flushed batch count out of range");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[37:32] == 6'd0) && (m_axis_tdata[73:68] == 6'd0))
        else $error("lengths not multiples of 64");

    a_unused_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[67:64] < 4'd8) |-> (m_axis_tdata[323:292] == 32'd0))
        else $error("unused last slot not zero");

endmodule

bind message_batch_coalescer mbc_checker u_mbc_checker (.*);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the message batch coalescer against a batch predictor.
`timescale 1ns / 1ps

module tb;
    import mbc_pkg::*;

    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic        is_msg;
        logic [31:0] dest;
        logic [31:0] len;
    } t_msg_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;

    message_batch_coalescer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_msg_cmd cmd_q[$];
    t_result  batch_q[$];
    t_msg_cmd cur_cmd;
    bit       idle_on = 1'b1;
    bit       hold_for_flush = 1'b0;
    int       send_gap = 0;
    int       rcv_stall = 0;
    int       mismatches = 0;
    int       stuck_cycles = 0;

    // batch predictor state
    logic [31:0] timeout_reg = TIMEOUT_RESET;
    logic [16:0] limit_reg = LIMIT_RESET;
    logic        batch_open = 1'b0;
    logic [31:0] tick_count = '0;
    logic [34:0] byte_sum = '0;
    logic [3:0]  msg_count = '0;
    t_slots      slot_len = '0;
    logic [31:0] last_dest = '0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result close_batch();
        t_result r;
        r.dest     = last_dest;
        r.send_len = byte_sum[31:0] + HEADER_BYTES;
        r.count    = msg_count;
        r.slots    = slot_len;
        r.run_end  = 1'b0;
        batch_open = 1'b0;
        tick_count = '0;
        byte_sum   = '0;
        msg_count  = '0;
        slot_len   = '0;
        return r;
    endfunction

    task automatic coalesce_step(input t_msg_cmd c);
        t_result     flushes[2];
        int          n;
        logic [31:0] rounded;
        n = 0;
        if (batch_open) begin
            tick_count = tick_count + 32'd1;
            if (tick_count >= timeout_reg) begin
                flushes[n] = close_batch();
                n++;
            end
        end
        if (c.is_msg) begin
            rounded = (c.len + ROUND_ADD) & ~ROUND_ADD;
            last_dest = c.dest;
            byte_sum = byte_sum + {3'b000, rounded};
            slot_len[msg_count[SLOT_IDX_W-1:0]] = rounded;
            msg_count = msg_count + 4'd1;
            if (byte_sum >= {18'd0, limit_reg} || msg_count == 4'(MAX_MESSAGES)) begin
                flushes[n] = close_batch();
                n++;
            end else begin
                batch_open = 1'b1;
            end
        end
        if (n > 0)
            flushes[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            batch_q.push_back(flushes[i]);
    endtask

    // sender
    always @(posedge i_clk) begin : drive_proc
        logic nv;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                coalesce_step(cur_cmd);
                nv = 1'b0;
                if (idle_on) begin
                    if ($urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 6);
                    else if ($urandom_range(0, 99) == 0)
                        hold_for_flush = 1'b1;
                end
            end
            if (hold_for_flush && batch_q.size() == 0)
                hold_for_flush = 1'b0;
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!hold_for_flush && cmd_q.size() != 0) begin
                    cur_cmd = cmd_q.pop_front();
                    s_axis_tdata <= {cur_cmd.len, cur_cmd.dest};
                    s_axis_tuser <= cur_cmd.is_msg;
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : check_proc
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.dest     = m_axis_tdata[31:0];
                got.send_len = m_axis_tdata[63:32];
                got.count    = m_axis_tdata[67:64];
                got.slots    = m_axis_tdata[323:68];
                got.run_end  = m_axis_tlast;
                if (batch_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected batch: dest %h len %h count %0d last %b",
                                 got.dest, got.send_len, got.count, got.run_end);
                end else begin
                    want = batch_q.pop_front();
                    if (got.dest !== want.dest || got.send_len !== want.send_len ||
                        got.count !== want.count || got.slots !== want.slots ||
                        got.run_end !== want.run_end) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("batch mismatch at %0t", $realtime);
                            $display("  dest %h/%h len %h/%h count %0d/%0d last %b/%b",
                                     got.dest, want.dest, got.send_len, want.send_len,
                                     got.count, want.count, got.run_end, want.run_end);
                            $display("  slots got %h", got.slots);
                            $display("  slots exp %h", want.slots);
                        end
                    end
                end
            end
            if (idle_on && rcv_stall == 0 && $urandom_range(0, 7) == 0)
                rcv_stall = $urandom_range(1, 6);
            if (rcv_stall > 0) begin
                rcv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic settle();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || s_axis_tvalid || batch_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BATCH_TIMEOUT)
            timeout_reg = val;
        else
            limit_reg = val[16:0];
    endtask

    task automatic push_cmd(input logic is_msg, input logic [31:0] dest, input logic [31:0] len);
        t_msg_cmd c;
        c.is_msg = is_msg;
        c.dest   = dest;
        c.len    = len;
        cmd_q.push_back(c);
    endtask

    function automatic t_msg_cmd random_cmd(input int msg_pct);
        t_msg_cmd c;
        c.is_msg = ($urandom_range(0, 99) < msg_pct);
        c.dest   = $urandom();
        case ($urandom_range(0, 9))
            0: c.len = $urandom();
            1: c.len = 32'hFFFF_FFC0 + $urandom_range(0, 63);
            2: c.len = $urandom_range(0, 63) << 6;
            default: c.len = $urandom_range(0, 700);
        endcase
        return c;
    endfunction

    task automatic random_phase(input logic [31:0] tmo, input logic [31:0] lim,
                                input int n, input int msg_pct);
        settle();
        write_reg(CFG_BATCH_TIMEOUT, tmo);
        write_reg(CFG_BYTE_LIMIT, lim);
        repeat (n) cmd_q.push_back(random_cmd(msg_pct));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: tick while idle, zero length, rounding wrap, full batch, exact limit
        push_cmd(1'b0, 32'h0, 32'h0);
        push_cmd(1'b1, 32'h0000_0000, 32'h0000_0000);
        push_cmd(1'b1, 32'hFFFF_FFFF, 32'h0000_0001);
        push_cmd(1'b1, 32'h1234_5678, 32'hFFFF_FFC1);
        push_cmd(1'b1, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
        push_cmd(1'b1, 32'h5A5A_5A5A, 32'h0000_0040);
        push_cmd(1'b1, 32'h0F0F_0F0F, 32'h0000_0041);
        push_cmd(1'b1, 32'hF0F0_F0F0, 32'h0000_0064);
        push_cmd(1'b1, 32'h8000_0001, 32'h0000_0FFF);
        push_cmd(1'b1, 32'h7FFF_FFFE, 32'hFFFF_FFC0);
        push_cmd(1'b1, 32'h0000_0011, 32'd4032);
        push_cmd(1'b1, 32'h0000_0022, 32'd1);

        // zero timeout: flush on tick, flush then reopen, flush then immediate flush
        settle();
        write_reg(CFG_BATCH_TIMEOUT, 32'd0);
        write_reg(CFG_BYTE_LIMIT, 32'd64);
        push_cmd(1'b1, 32'h0000_0101, 32'd0);
        push_cmd(1'b0, 32'h0, 32'h0);
        push_cmd(1'b1, 32'h0000_0102, 32'd0);
        push_cmd(1'b1, 32'h0000_0103, 32'd0);
        push_cmd(1'b1, 32'h0000_0104, 32'd5);
        push_cmd(1'b1, 32'h0000_0105, 32'd5);

        // short timeout with the limit at 0x10000
        settle();
        write_reg(CFG_BATCH_TIMEOUT, 32'd3);
        write_reg(CFG_BYTE_LIMIT, 32'h0001_0000);
        push_cmd(1'b1, 32'h0000_0201, 32'd10);
        repeat (3) push_cmd(1'b0, 32'h0, 32'h0);
        push_cmd(1'b1, 32'h0000_0202, 32'd20);
        repeat (2) push_cmd(1'b0, 32'h0, 32'h0);
        push_cmd(1'b1, 32'h0000_0203, 32'd30);

        // largest timeout, limit truncated to zero
        settle();
        write_reg(CFG_BATCH_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_BYTE_LIMIT, 32'hFFFE_0000);
        push_cmd(1'b1, 32'h0000_0301, 32'd0);
        push_cmd(1'b1, 32'h0000_0302, 32'hFFFF_FFFF);

        random_phase(32'd1000, 32'd4096, 140, 70);
        random_phase(32'd0, 32'd64, 130, 60);
        random_phase(32'd1, 32'd1000, 130, 65);
        random_phase($urandom_range(2, 20), $urandom_range(64, 4096), 140, 75);
        random_phase(32'hFFFF_FFFF, 32'h0001_0000, 140, 80);
        random_phase($urandom_range(5, 40), 32'h0001_0000, 140, 70);
        random_phase($urandom(), $urandom(), 130, 70);
        random_phase($urandom_range(0, 10), 32'd0, 130, 60);
        idle_on = 1'b0;
        random_phase($urandom_range(3, 30), $urandom_range(64, 65536), 140, 75);

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && batch_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
